### design/sv39pte_pkg.sv
// ----------------------------------------------------------------------------
// sv39pte_pkg
// Shared types and constants of the Sv39 page table engine: field widths,
// request and status codes, and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package sv39pte_pkg;

  // field widths
  localparam int VA_W     = 39;
  localparam int PA_W     = 56;
  localparam int PPN_W    = 44;
  localparam int PTE_W    = 64;
  localparam int OFFSET_W = 12;
  localparam int VPN_W    = 9;
  localparam int FLAGS_W  = 8;

  // pte layout
  localparam int PTE_V_BIT   = 0;
  localparam int PTE_PPN_LSB = 10;

  // walk levels
  localparam logic [1:0] LVL_ROOT = 2'd2;
  localparam logic [1:0] LVL_LEAF = 2'd0;

  typedef enum logic [1:0] {
    REQ_TRANSLATE = 2'd0,
    REQ_MAP       = 2'd1,
    REQ_UNMAP     = 2'd2,
    REQ_NONE      = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_MAPPED = 2'd1,
    ST_FULL       = 2'd2,
    ST_OUTSIDE    = 2'd3
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic    clear_step;
    logic    load;
    logic    rd;
    logic    alloc;
    logic    descend;
    logic    wr_leaf;
    logic    out_load;
    status_t out_status;
    logic    out_leaf;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_done;
    logic level_zero;
    logic pte_v;
    logic full;
    logic outside;
    req_t req;
  } dp_stat_t;

endpackage

### design/sv39pte_dp.sv
// ----------------------------------------------------------------------------
// sv39pte_dp
// Datapath: request registers, walk pointer, page allocator, table store
// with per-entry allocation mark, and the result register.
// ----------------------------------------------------------------------------
module sv39pte_dp #(
  parameter int TABLE_PAGES = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  sv39pte_pkg::dp_cmd_t           cmd,
  output sv39pte_pkg::dp_stat_t          stat,
  input  logic                           cfg_wr_en,
  input  logic [sv39pte_pkg::PPN_W-1:0]  cfg_wr_data,
  input  logic [1:0]                     req_type,
  input  logic [sv39pte_pkg::VA_W-1:0]   virt_addr,
  input  logic [sv39pte_pkg::PA_W-1:0]   phys_addr,
  input  logic [sv39pte_pkg::FLAGS_W-1:0] perm_flags,
  output logic [1:0]                     status,
  output logic [sv39pte_pkg::PA_W-1:0]   result_addr,
  output logic                           leaf_valid
);

  localparam int PAGE_W = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  localparam int NFP_W  = $clog2(TABLE_PAGES + 1);
  localparam int ADDR_W = PAGE_W + sv39pte_pkg::VPN_W;
  localparam int DEPTH  = TABLE_PAGES * (2 ** sv39pte_pkg::VPN_W);
  localparam int MEM_W  = sv39pte_pkg::PTE_W + 1;

  // configuration
  logic [sv39pte_pkg::PPN_W-1:0]   table_base_ppn;

  // request registers
  sv39pte_pkg::req_t               req;
  logic [sv39pte_pkg::VA_W-1:0]    va;
  logic [sv39pte_pkg::PA_W-1:0]    pa;
  logic [sv39pte_pkg::FLAGS_W-1:0] flags;

  // walk state
  logic [PAGE_W-1:0]               page;
  logic [1:0]                      level;
  logic [NFP_W-1:0]                next_free_page;
  logic [ADDR_W-1:0]               clr_addr;

  // store: bit 64 marks an entry written while its page was allocated
  logic [MEM_W-1:0]                mem [DEPTH];
  logic [MEM_W-1:0]                rdata;

  logic [sv39pte_pkg::VPN_W-1:0]   vpn;
  logic [ADDR_W-1:0]               walk_addr;
  logic                            page_alloc;
  logic [sv39pte_pkg::PTE_W-1:0]   pte;
  logic [sv39pte_pkg::PPN_W-1:0]   pte_ppn;
  logic [sv39pte_pkg::PPN_W-1:0]   rel;
  logic [sv39pte_pkg::PPN_W-1:0]   fresh_ppn;
  logic                            we;
  logic [ADDR_W-1:0]               waddr;
  logic [MEM_W-1:0]                wdata;

  // base register
  always_ff @(posedge clk) begin
    if (rst) begin
      table_base_ppn <= '0;
    end else if (cfg_wr_en) begin
      table_base_ppn <= cfg_wr_data;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req   <= sv39pte_pkg::req_t'(req_type);
      va    <= virt_addr;
      pa    <= phys_addr;
      flags <= perm_flags;
    end
  end

  // entry index for the current level
  always_comb begin
    unique case (level)
      2'd2:    vpn = va[38:30];
      2'd1:    vpn = va[29:21];
      default: vpn = va[20:12];
    endcase
  end

  assign walk_addr  = {page, vpn};
  assign page_alloc = NFP_W'(page) < next_free_page;

  // an entry left over from before its page was handed out reads as zero
  assign pte     = (page_alloc && !rdata[MEM_W-1]) ? '0 : rdata[sv39pte_pkg::PTE_W-1:0];
  assign pte_ppn = pte[sv39pte_pkg::PTE_PPN_LSB +: sv39pte_pkg::PPN_W];
  assign rel     = pte_ppn - table_base_ppn;
  assign fresh_ppn = table_base_ppn + sv39pte_pkg::PPN_W'(next_free_page);

  // walk pointer, allocator and clear counter
  always_ff @(posedge clk) begin
    if (rst) begin
      next_free_page <= NFP_W'(1);
      clr_addr       <= '0;
      page           <= '0;
      level          <= sv39pte_pkg::LVL_ROOT;
    end else begin
      if (cmd.clear_step) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (cmd.load) begin
        page  <= '0;
        level <= sv39pte_pkg::LVL_ROOT;
      end else if (cmd.alloc) begin
        page           <= next_free_page[PAGE_W-1:0];
        level          <= level - 2'd1;
        next_free_page <= next_free_page + NFP_W'(1);
      end else if (cmd.descend) begin
        page  <= rel[PAGE_W-1:0];
        level <= level - 2'd1;
      end
    end
  end

  // write port select
  always_comb begin
    we    = 1'b0;
    waddr = walk_addr;
    wdata = '0;
    priority if (cmd.clear_step) begin
      we    = 1'b1;
      waddr = clr_addr;
    end else if (cmd.alloc) begin
      // the fresh page is not cleared; its stale entries read as zero by their marks
      we    = 1'b1;
      wdata = {(NFP_W'(page) <= next_free_page), 10'd0, fresh_ppn, 9'd0, 1'b1};
    end else if (cmd.wr_leaf) begin
      we = 1'b1;
      if (req == sv39pte_pkg::REQ_MAP) begin
        wdata = {page_alloc, 10'd0, pa[sv39pte_pkg::PA_W-1:sv39pte_pkg::OFFSET_W],
                 2'd0, flags | sv39pte_pkg::FLAGS_W'(1)};
      end else begin
        wdata = {page_alloc, 64'd0};
      end
    end
  end

  // table store
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rdata <= mem[walk_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status      <= cmd.out_status;
      result_addr <= cmd.out_leaf ? {pte_ppn, va[sv39pte_pkg::OFFSET_W-1:0]} : '0;
      leaf_valid  <= cmd.out_leaf & pte[sv39pte_pkg::PTE_V_BIT];
    end
  end

  // status to controller
  assign stat.clear_done = clr_addr == ADDR_W'(DEPTH - 1);
  assign stat.level_zero = level == sv39pte_pkg::LVL_LEAF;
  assign stat.pte_v      = pte[sv39pte_pkg::PTE_V_BIT];
  assign stat.full       = next_free_page == NFP_W'(TABLE_PAGES);
  assign stat.outside    = rel >= sv39pte_pkg::PPN_W'(TABLE_PAGES);
  assign stat.req        = req;

endmodule

### design/sv39pte_ctrl.sv
// ----------------------------------------------------------------------------
// sv39pte_ctrl
// Controller: sequences the clearing pass, request capture, the read and
// check steps of each walk level, and the hand-off to the result register.
// ----------------------------------------------------------------------------
module sv39pte_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            req_type,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  sv39pte_pkg::dp_stat_t stat,
  output sv39pte_pkg::dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_CHK,
    S_FIN
  } state_t;

  state_t               state;
  sv39pte_pkg::status_t fin_status;
  logic                 fin_leaf;

  logic                 slot_free;
  logic                 chk_done;
  sv39pte_pkg::status_t chk_status;
  logic                 chk_leaf;

  assign in_stall  = state != S_IDLE;
  assign slot_free = !out_valid || !out_stall;

  // outcome of the check step
  always_comb begin
    chk_done   = 1'b0;
    chk_status = sv39pte_pkg::ST_OK;
    chk_leaf   = 1'b0;
    if (stat.level_zero) begin
      chk_done = 1'b1;
      chk_leaf = stat.req == sv39pte_pkg::REQ_TRANSLATE;
    end else if (!stat.pte_v) begin
      if (stat.req != sv39pte_pkg::REQ_MAP) begin
        chk_done   = 1'b1;
        chk_status = sv39pte_pkg::ST_NOT_MAPPED;
      end else if (stat.full) begin
        chk_done   = 1'b1;
        chk_status = sv39pte_pkg::ST_FULL;
      end
    end else if (stat.outside) begin
      chk_done   = 1'b1;
      chk_status = sv39pte_pkg::ST_OUTSIDE;
    end
  end

  // commands
  always_comb begin
    cmd = '0;
    unique case (state)
      S_CLEAR: cmd.clear_step = 1'b1;
      S_IDLE:  cmd.load = in_valid;
      S_RD:    cmd.rd = 1'b1;
      S_CHK: begin
        cmd.out_status = chk_status;
        cmd.out_leaf   = chk_leaf;
        cmd.out_load   = chk_done && slot_free;
        cmd.wr_leaf    = stat.level_zero && (stat.req == sv39pte_pkg::REQ_MAP ||
                                             stat.req == sv39pte_pkg::REQ_UNMAP);
        cmd.alloc      = !stat.level_zero && !stat.pte_v &&
                         stat.req == sv39pte_pkg::REQ_MAP && !stat.full;
        cmd.descend    = !chk_done && !cmd.alloc;
      end
      S_FIN: begin
        cmd.out_status = fin_status;
        cmd.out_leaf   = fin_leaf;
        cmd.out_load   = slot_free;
      end
      default: cmd = '0;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      out_valid  <= 1'b0;
      fin_status <= sv39pte_pkg::ST_OK;
      fin_leaf   <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (stat.clear_done) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            if (req_type == sv39pte_pkg::REQ_NONE) begin
              fin_status <= sv39pte_pkg::ST_OK;
              fin_leaf   <= 1'b0;
              state      <= S_FIN;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_RD: state <= S_CHK;
        S_CHK: begin
          if (!chk_done) begin
            state <= S_RD;
          end else if (slot_free) begin
            state <= S_IDLE;
          end else begin
            fin_status <= chk_status;
            fin_leaf   <= chk_leaf;
            state      <= S_FIN;
          end
        end
        S_FIN: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

endmodule

### design/sv39_page_table_engine.sv
// ----------------------------------------------------------------------------
// sv39_page_table_engine
// Sv39 page table walker with an internal table store: translate, map and
// unmap one page per request, one result per request.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all TABLE_PAGES * 512
// entries of the table store (32768 at the default) with in_stall high; the
// base register can be written meanwhile. It then takes one request at a
// time. Each walk level has two steps, a registered read of the store and
// a check step that may also write an allocated pointer or the leaf; a
// walk that stops early on an invalid or out-of-store pointer finishes
// sooner than a full three-level walk, and a result held by out_stall
// keeps the following walk waiting in its last step. Table pages handed
// out by a map need no clearing time: each entry carries a mark telling
// whether it was written after its page was handed out, and stale
// entries read as zero.
// ----------------------------------------------------------------------------
module sv39_page_table_engine #(
  parameter int TABLE_PAGES = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [sv39pte_pkg::PPN_W-1:0]   cfg_wr_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      req_type,
  input  logic [sv39pte_pkg::VA_W-1:0]    virt_addr,
  input  logic [sv39pte_pkg::PA_W-1:0]    phys_addr,
  input  logic [sv39pte_pkg::FLAGS_W-1:0] perm_flags,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      status,
  output logic [sv39pte_pkg::PA_W-1:0]    result_addr,
  output logic                            leaf_valid
);

  sv39pte_pkg::dp_cmd_t  cmd;
  sv39pte_pkg::dp_stat_t stat;

  // sequencing
  sv39pte_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // store, walk registers and result
  sv39pte_dp #(
    .TABLE_PAGES (TABLE_PAGES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req_type    (req_type),
    .virt_addr   (virt_addr),
    .phys_addr   (phys_addr),
    .perm_flags  (perm_flags),
    .status      (status),
    .result_addr (result_addr),
    .leaf_valid  (leaf_valid)
  );

endmodule

### design/sv39pte_chk.sv
// ----------------------------------------------------------------------------
// sv39pte_chk
// Port-level checks of the page table engine, bound to the top level.
// ----------------------------------------------------------------------------
module sv39pte_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [1:0]                    status,
  input logic [sv39pte_pkg::PA_W-1:0]  result_addr,
  input logic                          leaf_valid
);

  // reset starts the clearing pass, so no beat is taken right after it
  assert property (@(posedge clk) rst |=> in_stall)
    else $error("input taken right after reset");

  // one request at a time: a taken beat closes the input
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input open in the cycle after a taken beat");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(status) &&
                                  $stable(result_addr) && $stable(leaf_valid)))
    else $error("stalled result changed");

  // only a successful walk returns an address
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != sv39pte_pkg::ST_OK) |-> (result_addr == '0 && !leaf_valid))
    else $error("address returned with an error status");

endmodule

bind sv39_page_table_engine sv39pte_chk u_sv39pte_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .result_addr (result_addr),
  .leaf_valid  (leaf_valid)
);

### bench/sv39_walk_checker.sv
// ----------------------------------------------------------------------------
// sv39_walk_checker
// Watches the request, response and base register ports of the Sv39 page
// table engine, walks its own copy of the table store for every accepted
// request, and compares each response beat against the oldest prediction.
// ----------------------------------------------------------------------------
module sv39_walk_checker #(
  parameter int TABLE_PAGES = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [sv39pte_pkg::PPN_W-1:0]   cfg_wr_data,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [1:0]                      req_type,
  input  logic [sv39pte_pkg::VA_W-1:0]    virt_addr,
  input  logic [sv39pte_pkg::PA_W-1:0]    phys_addr,
  input  logic [sv39pte_pkg::FLAGS_W-1:0] perm_flags,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [1:0]                      status,
  input  logic [sv39pte_pkg::PA_W-1:0]    result_addr,
  input  logic                            leaf_valid,
  input  logic                            end_check,
  output int                              pending,
  output int                              fail_count
);

  localparam int ENTRIES = 512;
  localparam int SLOTS   = TABLE_PAGES * ENTRIES;

  typedef struct packed {
    sv39pte_pkg::status_t         st;
    logic [sv39pte_pkg::PA_W-1:0] addr;
    logic                         lv;
  } walk_response_t;

  // shadow table store and allocator
  logic [sv39pte_pkg::PTE_W-1:0] shadow_ptes [0:SLOTS-1];
  int unsigned                   next_table_page;
  logic [sv39pte_pkg::PPN_W-1:0] base_ppn;
  walk_response_t                pending_responses [$];
  int                            mismatch_reports;
  int                            response_beats;
  bit                            end_done;

  // walk levels 2 and 1, allocating missing tables when grow is set
  task automatic walk_table(input logic [sv39pte_pkg::VA_W-1:0] va, input bit grow,
                            output sv39pte_pkg::status_t st, output int unsigned slot);
    int unsigned                   page;
    int unsigned                   idx;
    logic [sv39pte_pkg::PTE_W-1:0] pte;
    logic [sv39pte_pkg::PPN_W-1:0] rel;
    logic [sv39pte_pkg::PPN_W-1:0] fresh_ppn;
    page = 0;
    st   = sv39pte_pkg::ST_OK;
    slot = 0;
    for (int lvl = 2; lvl > 0; lvl--) begin
      idx = page * ENTRIES +
            va[sv39pte_pkg::OFFSET_W + sv39pte_pkg::VPN_W * lvl +: sv39pte_pkg::VPN_W];
      pte = shadow_ptes[idx];
      if (!pte[sv39pte_pkg::PTE_V_BIT]) begin
        if (!grow) begin
          st = sv39pte_pkg::ST_NOT_MAPPED;
          return;
        end
        if (next_table_page >= TABLE_PAGES) begin
          st = sv39pte_pkg::ST_FULL;
          return;
        end
        // fresh table page starts cleared
        for (int i = 0; i < ENTRIES; i++)
          shadow_ptes[next_table_page * ENTRIES + i] = '0;
        fresh_ppn = base_ppn + sv39pte_pkg::PPN_W'(next_table_page);
        pte = {10'b0, fresh_ppn, 10'b0};
        pte[sv39pte_pkg::PTE_V_BIT] = 1'b1;
        next_table_page++;
        shadow_ptes[idx] = pte;
      end
      rel = pte[sv39pte_pkg::PTE_PPN_LSB +: sv39pte_pkg::PPN_W] - base_ppn;
      if (rel >= sv39pte_pkg::PPN_W'(TABLE_PAGES)) begin
        st = sv39pte_pkg::ST_OUTSIDE;
        return;
      end
      page = int'(rel[15:0]);
    end
    slot = page * ENTRIES + va[sv39pte_pkg::OFFSET_W +: sv39pte_pkg::VPN_W];
  endtask

  // expected response of one request, updating the shadow store
  task automatic predict_response(input sv39pte_pkg::req_t rq,
                                  input logic [sv39pte_pkg::VA_W-1:0] va,
                                  input logic [sv39pte_pkg::PA_W-1:0] pa,
                                  input logic [sv39pte_pkg::FLAGS_W-1:0] flags,
                                  output walk_response_t r);
    int unsigned                   slot;
    logic [sv39pte_pkg::PTE_W-1:0] leaf;
    r = '{st: sv39pte_pkg::ST_OK, addr: '0, lv: 1'b0};
    unique case (rq)
      sv39pte_pkg::REQ_TRANSLATE: begin
        walk_table(va, 1'b0, r.st, slot);
        if (r.st == sv39pte_pkg::ST_OK) begin
          leaf   = shadow_ptes[slot];
          r.addr = {leaf[sv39pte_pkg::PTE_PPN_LSB +: sv39pte_pkg::PPN_W],
                    va[sv39pte_pkg::OFFSET_W-1:0]};
          r.lv   = leaf[sv39pte_pkg::PTE_V_BIT];
        end
      end
      sv39pte_pkg::REQ_MAP: begin
        walk_table(va, 1'b1, r.st, slot);
        if (r.st == sv39pte_pkg::ST_OK)
          shadow_ptes[slot] = {10'b0, pa[sv39pte_pkg::PA_W-1:sv39pte_pkg::OFFSET_W],
                               2'b00, flags | 8'h01};
      end
      sv39pte_pkg::REQ_UNMAP: begin
        walk_table(va, 1'b0, r.st, slot);
        if (r.st == sv39pte_pkg::ST_OK)
          shadow_ptes[slot] = '0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : monitor
    walk_response_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++)
        shadow_ptes[i] = '0;
      next_table_page  = 1;
      base_ppn         = '0;
      fail_count       = 0;
      mismatch_reports = 0;
      response_beats   = 0;
      end_done         = 0;
      pending_responses.delete();
    end else begin
      // response beat against the oldest prediction
      if (out_valid && !out_stall) begin
        if (pending_responses.size() == 0) begin
          fail_count++;
          if (mismatch_reports < 10)
            $display("response %0d arrived with nothing outstanding", response_beats);
          mismatch_reports++;
        end else begin
          want = pending_responses.pop_front();
          if (status !== want.st || result_addr !== want.addr ||
              leaf_valid !== want.lv) begin
            fail_count++;
            if (mismatch_reports < 10)
              $display("response %0d: status %0d/%0d addr %h/%h leaf %b/%b (exp/got)",
                       response_beats, want.st, status, want.addr, result_addr,
                       want.lv, leaf_valid);
            mismatch_reports++;
          end
        end
        response_beats++;
      end
      if (cfg_wr_en)
        base_ppn = cfg_wr_data;
      // request beat
      if (in_valid && !in_stall) begin
        predict_response(sv39pte_pkg::req_t'(req_type), virt_addr, phys_addr,
                         perm_flags, want);
        pending_responses.push_back(want);
      end
      // anything still outstanding at the end is lost
      if (end_check && !end_done) begin
        end_done = 1;
        if (pending_responses.size() != 0) begin
          fail_count += pending_responses.size();
          $display("%0d responses never arrived", pending_responses.size());
        end
      end
    end
    pending = pending_responses.size();
  end

endmodule

### bench/tb_sv39_page_table_engine.sv
// ----------------------------------------------------------------------------
// tb_sv39_page_table_engine
// Drives translate, map and unmap requests into the Sv39 page table engine
// under random gaps and stalls, across several table base settings, and
// reports the verdict kept by the walk checker.
// ----------------------------------------------------------------------------
module tb_sv39_page_table_engine;

  localparam int TABLE_PAGES = 64;
  localparam int POOL        = 18;
  localparam int SETTLE      = 20;

  logic                            clk;
  logic                            rst;
  logic                            cfg_wr_en;
  logic [sv39pte_pkg::PPN_W-1:0]   cfg_wr_data;
  logic                            in_valid;
  logic                            in_stall;
  logic [1:0]                      req_type;
  logic [sv39pte_pkg::VA_W-1:0]    virt_addr;
  logic [sv39pte_pkg::PA_W-1:0]    phys_addr;
  logic [sv39pte_pkg::FLAGS_W-1:0] perm_flags;
  logic                            out_valid;
  logic                            out_stall;
  logic [1:0]                      status;
  logic [sv39pte_pkg::PA_W-1:0]    result_addr;
  logic                            leaf_valid;
  logic                            end_check;
  int                              pending;
  int                              fail_count;

  // pacing controls: no_idle is shared by both sides, rx_hold_req is for the response side
  bit no_idle;
  bit rx_hold_req;

  // address regions that most requests reuse
  logic [sv39pte_pkg::VPN_W-1:0] pool_vpn2 [POOL];
  logic [sv39pte_pkg::VPN_W-1:0] pool_vpn1 [POOL];

  sv39_page_table_engine #(.TABLE_PAGES(TABLE_PAGES)) uut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .virt_addr(virt_addr),
    .phys_addr(phys_addr), .perm_flags(perm_flags),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .result_addr(result_addr), .leaf_valid(leaf_valid)
  );

  sv39_walk_checker #(.TABLE_PAGES(TABLE_PAGES)) u_walk_chk (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .virt_addr(virt_addr),
    .phys_addr(phys_addr), .perm_flags(perm_flags),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .result_addr(result_addr), .leaf_valid(leaf_valid),
    .end_check(end_check), .pending(pending), .fail_count(fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  initial begin
    #20000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // response side stalls, with an occasional long hold
  initial begin
    int unsigned run_left;
    int unsigned hold_left;
    bit          hold_seen;
    out_stall = 1'b0;
    run_left  = 0;
    hold_left = 0;
    hold_seen = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req && !hold_seen) begin
        hold_left = 400;
      end
      hold_seen = rx_hold_req;
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (no_idle) begin
        out_stall = 1'b0;
      end else if (run_left > 0) begin
        run_left--;
      end else begin
        out_stall = ($urandom_range(0, 2) == 0);
        run_left  = pick_gap();
      end
    end
  end

  // one request beat, entered and left at a falling edge
  task automatic send_req(input sv39pte_pkg::req_t rq,
                          input logic [sv39pte_pkg::VA_W-1:0] va,
                          input logic [sv39pte_pkg::PA_W-1:0] pa,
                          input logic [sv39pte_pkg::FLAGS_W-1:0] fl);
    int unsigned gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_type   = rq;
    virt_addr  = va;
    phys_addr  = pa;
    perm_flags = fl;
    in_valid   = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // drop valid and wait for every response
  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // base register write once no response is outstanding
  task automatic set_table_base(input logic [sv39pte_pkg::PPN_W-1:0] v);
    drain();
    repeat (12) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
  endtask

  // random requests, mostly inside the reused regions
  task automatic run_random(input int n);
    logic [63:0]                   raw;
    logic [sv39pte_pkg::VA_W-1:0]  va;
    logic [sv39pte_pkg::VPN_W-1:0] vpn0;
    int unsigned                   r;
    int unsigned                   k;
    int unsigned                   pick;
    sv39pte_pkg::req_t             rq;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 85) begin
        pick = $urandom_range(0, POOL - 1);
        vpn0 = ($urandom_range(0, 3) == 0) ? sv39pte_pkg::VPN_W'($urandom) :
                                             sv39pte_pkg::VPN_W'($urandom_range(0, 7));
        va   = {pool_vpn2[pick], pool_vpn1[pick], vpn0,
                sv39pte_pkg::OFFSET_W'($urandom)};
        k    = $urandom_range(0, 99);
        rq   = (k < 45) ? sv39pte_pkg::REQ_TRANSLATE :
               (k < 80) ? sv39pte_pkg::REQ_MAP :
               (k < 95) ? sv39pte_pkg::REQ_UNMAP : sv39pte_pkg::REQ_NONE;
      end else begin
        raw = {$urandom, $urandom};
        va  = raw[sv39pte_pkg::VA_W-1:0];
        rq  = sv39pte_pkg::req_t'($urandom_range(0, 3));
      end
      raw = {$urandom, $urandom};
      send_req(rq, va, raw[sv39pte_pkg::PA_W-1:0], sv39pte_pkg::FLAGS_W'($urandom));
    end
  endtask

  initial begin
    logic [63:0]                  raw;
    logic [sv39pte_pkg::VA_W-1:0] va_top;
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    req_type    = sv39pte_pkg::REQ_TRANSLATE;
    virt_addr   = '0;
    phys_addr   = '0;
    perm_flags  = '0;
    end_check   = 1'b0;
    no_idle     = 1'b0;
    rx_hold_req = 1'b0;
    for (int i = 0; i < POOL; i++) begin
      pool_vpn2[i] = (i % 3 == 0) ? sv39pte_pkg::VPN_W'($urandom) : pool_vpn2[i - i % 3];
      pool_vpn1[i] = sv39pte_pkg::VPN_W'($urandom);
    end
    va_top = '1;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // base at zero, directed corners
    set_table_base('0);
    send_req(sv39pte_pkg::REQ_TRANSLATE, '0, '0, '0);            // empty root
    send_req(sv39pte_pkg::REQ_UNMAP, 39'h12_3456_789A, '0, '0);  // unmap on empty root
    send_req(sv39pte_pkg::REQ_NONE, va_top, '1, '1);             // ignored request
    send_req(sv39pte_pkg::REQ_MAP, '0, '1, '0);                  // allocates two tables
    send_req(sv39pte_pkg::REQ_TRANSLATE, 39'h0FFF, '0, '0);      // full offset
    send_req(sv39pte_pkg::REQ_MAP, va_top, '0, '1);
    send_req(sv39pte_pkg::REQ_TRANSLATE, va_top, '0, '0);
    send_req(sv39pte_pkg::REQ_MAP, {9'd0, 9'd0, 9'd1, 12'd0}, 56'hA5_5A5A_5A5A_5000, 8'h0E);
    // leaf never set
    send_req(sv39pte_pkg::REQ_TRANSLATE, {9'd0, 9'd0, 9'd2, 12'h123}, '0, '0);
    send_req(sv39pte_pkg::REQ_TRANSLATE, {9'd0, 9'd0, 9'd1, 12'h7FF}, '0, '0);
    send_req(sv39pte_pkg::REQ_UNMAP, '0, '0, '0);
    send_req(sv39pte_pkg::REQ_TRANSLATE, 39'h0ABC, '0, '0);      // leaf cleared
    send_req(sv39pte_pkg::REQ_UNMAP, '0, '0, '0);                // leaf already clear
    send_req(sv39pte_pkg::REQ_UNMAP, va_top, '0, '0);
    // missing level 1
    send_req(sv39pte_pkg::REQ_TRANSLATE, {9'd0, 9'd5, 9'd0, 12'd0}, '0, '0);
    send_req(sv39pte_pkg::REQ_UNMAP, {9'd0, 9'd5, 9'd3, 12'd0}, '0, '0);
    send_req(sv39pte_pkg::REQ_MAP, '0, 56'hFF_FFFF_FFFF_FFFF, 8'h80);
    send_req(sv39pte_pkg::REQ_TRANSLATE, 39'h0001, '0, '0);
    send_req(sv39pte_pkg::REQ_NONE, '0, '0, '0);
    run_random(300);
    no_idle = 1'b1;
    run_random(80);
    // long response hold while requests keep coming
    rx_hold_req = 1'b1;
    run_random(40);
    no_idle = 1'b0;
    run_random(300);

    // all-ones base, old pointers shift by one page
    set_table_base('1);
    run_random(300);

    // random base, old pointers fall outside the store
    raw = {$urandom, $urandom};
    set_table_base(raw[sv39pte_pkg::PPN_W-1:0]);
    send_req(sv39pte_pkg::REQ_TRANSLATE, '0, '0, '0);
    send_req(sv39pte_pkg::REQ_MAP, '0, '1, 8'h06);
    run_random(150);

    // back to zero
    set_table_base('0);
    run_random(250);
    drain();
    no_idle = 1'b1;
    run_random(60);
    no_idle = 1'b0;
    run_random(250);

    // small nonzero base
    set_table_base(44'd3);
    run_random(220);

    drain();
    repeat (SETTLE) @(negedge clk);
    end_check = 1'b1;
    @(negedge clk);
    @(negedge clk);
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
